/* hdl/nre_pkg.sv */
`default_nettype none

package nre_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DEGREE_BITS = 5;
    localparam int ROOT_W      = 48;
    localparam int LIMB_W      = 32;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_MAX_DEGREE = 31;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [DEGREE_BITS-1:0]       degree;
    } t_req;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root;
        logic                     status;
    } t_rsp;

endpackage

`default_nettype wire

/* hdl/nre_limb_mac.sv */
`default_nettype none

module nre_limb_mac (
    input  wire logic [nre_pkg::LIMB_W-1:0]   i_a,
    input  wire logic [nre_pkg::LIMB_W-1:0]   i_b,
    input  wire logic [nre_pkg::LIMB_W-1:0]   i_acc,
    input  wire logic [nre_pkg::LIMB_W-1:0]   i_cin,
    output logic      [2*nre_pkg::LIMB_W-1:0] o_sum
);
    import nre_pkg::*;

    // a*b + acc + cin always fits in two limbs
    assign o_sum = (2*LIMB_W)'(i_a) * (2*LIMB_W)'(i_b)
                 + (2*LIMB_W)'(i_acc) + (2*LIMB_W)'(i_cin);

endmodule

`default_nettype wire

/* hdl/nre_tgt_limb.sv */
`default_nettype none

module nre_tgt_limb #(
    parameter int IDX_W = 5,
    parameter int SH_W  = 9
) (
    input  wire logic [nre_pkg::VALUE_BITS-1:0] i_mag,
    input  wire logic [SH_W-1:0]                i_shift,
    input  wire logic [IDX_W-1:0]               i_index,
    output logic      [nre_pkg::LIMB_W-1:0]     o_limb
);
    import nre_pkg::*;

    localparam int DW = IDX_W + SH_W + $clog2(LIMB_W) + 2;
    localparam int PW = VALUE_BITS + 2*LIMB_W;
    localparam int EW = $clog2(PW + 1);

    logic signed [DW-1:0] w_e;
    logic [PW-1:0]        w_pad;
    logic [PW-1:0]        w_sh;

    // limb i_index of (i_mag << i_shift), taken from a zero-padded window
    assign w_pad = {LIMB_W'(0), i_mag, LIMB_W'(0)};
    assign w_e   = $signed(DW'(i_index) * DW'(LIMB_W)) - $signed(DW'(i_shift))
                 + $signed(DW'(LIMB_W));

    always_comb begin
        w_sh   = w_pad >> w_e[EW-1:0];
        o_limb = w_sh[LIMB_W-1:0];
        if (w_e < 0 || w_e > $signed(DW'(VALUE_BITS + LIMB_W))) begin
            o_limb = '0;
        end
    end

endmodule

`default_nettype wire

/* hdl/nth_root_engine_core.sv */
// nth_root_engine_core
// Request channel (i_req_valid / o_req_ready / i_req): a signed value and a root
// degree. Response channel (o_rsp_valid / i_rsp_ready / o_rsp): the root in signed
// fixed point with FRAC_BITS fraction bits, truncated toward zero, and a status
// bit that flags degree zero, a degree above MAX_DEGREE or an even root of a
// negative value.
// One request is in work at a time; o_req_ready is high only when the sequencer
// is idle. Errors and degree one are answered without a search. Otherwise the
// result bits are found one at a time, top bit first, by raising the trial root
// to the degree with a single shared 32x32 limb multiply-accumulate; each
// multiply is followed by a top-down compare against the target, and a trial
// stops as soon as the power passes the target.
// The response sits in an output register; a new request is accepted while it
// waits, and a finished search holds until that register is free.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_rsp_valid.
`default_nettype none

module nth_root_engine_core #(
    parameter int FRAC_BITS  = nre_pkg::DEF_FRAC_BITS,
    parameter int MAX_DEGREE = nre_pkg::DEF_MAX_DEGREE
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire nre_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output nre_pkg::t_rsp      o_rsp
);
    import nre_pkg::*;

    localparam int ROOT_BITS = (VALUE_BITS + 1) / 2 + FRAC_BITS;
    localparam int TD        = (ROOT_BITS + LIMB_W - 1) / LIMB_W;
    localparam int LT_MAX    = (VALUE_BITS + FRAC_BITS * MAX_DEGREE + LIMB_W - 1) / LIMB_W;
    localparam int NL        = LT_MAX + TD;
    localparam int IW        = $clog2(NL);
    localparam int LW        = $clog2(NL + 1);
    localparam int KW        = (TD > 1) ? $clog2(TD) : 1;
    localparam int BW        = $clog2(ROOT_BITS);
    localparam int MW        = $clog2(MAX_DEGREE + 1);
    localparam int SHW       = $clog2(FRAC_BITS * MAX_DEGREE + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRIAL = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic [DEGREE_BITS-1:0]  r_m, n_m;
    logic [SHW-1:0]          r_shift, n_shift;
    logic [LW-1:0]           r_lt, n_lt;
    logic [ROOT_BITS-1:0]    r_root, n_root;
    logic [BW-1:0]           r_bit, n_bit;
    logic [LW-1:0]           r_len, n_len;
    logic                    r_src, n_src;
    logic                    r_one, n_one;
    logic [IW-1:0]           r_i, n_i;
    logic [KW-1:0]           r_kd, n_kd;
    logic [LIMB_W-1:0]       r_carry, n_carry;
    logic [MW-1:0]           r_cnt, n_cnt;
    logic [IW-1:0]           r_j, n_j;
    logic                    r_srch, n_srch;
    logic [ROOT_W-1:0]       r_res_root, n_res_root;
    logic                    r_res_status, n_res_status;
    logic                    r_out_valid, n_out_valid;
    t_rsp                    r_out, n_out;

    logic [LIMB_W-1:0]       r_pw0 [NL];
    logic [LIMB_W-1:0]       r_pw1 [NL];

    logic [ROOT_BITS-1:0]    w_t;
    logic [TD*LIMB_W-1:0]    w_t_ext;
    logic [LIMB_W-1:0]       w_dig;
    logic [IW-1:0]           w_addr_s;
    logic [IW-1:0]           w_addr_d;
    logic [LIMB_W-1:0]       w_src_rd;
    logic [LIMB_W-1:0]       w_dst_rd;
    logic [LIMB_W-1:0]       w_mac_a;
    logic [LIMB_W-1:0]       w_mac_acc;
    logic [2*LIMB_W-1:0]     w_mac_sum;
    logic [LIMB_W-1:0]       w_tl;
    logic [LIMB_W-1:0]       w_pl;
    logic                    w_we;
    logic [LIMB_W-1:0]       w_wd;
    logic [LW-1:0]           w_len_nx;
    logic                    w_accept;
    logic                    w_in_neg;
    logic [VALUE_BITS-1:0]   w_in_mag;
    logic                    w_in_err;
    logic [ROOT_W-1:0]       w_pass_root;
    logic [ROOT_W-1:0]       w_srch_root;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
    assign w_accept    = i_req_valid && o_req_ready;

    assign w_t      = r_root | (ROOT_BITS'(1) << r_bit);
    assign w_t_ext  = (TD*LIMB_W)'(w_t);
    assign w_dig    = w_t_ext[LIMB_W*r_kd +: LIMB_W];
    assign w_addr_s = (r_state == S_CMP) ? r_j : r_i;
    assign w_addr_d = r_i + IW'(r_kd);
    assign w_src_rd = r_src ? r_pw1[w_addr_s] : r_pw0[w_addr_s];
    assign w_dst_rd = r_src ? r_pw0[w_addr_d] : r_pw1[w_addr_d];
    assign w_mac_a  = r_one ? ((r_i == '0) ? LIMB_W'(1) : '0) : w_src_rd;
    assign w_mac_acc = (r_kd == '0) ? '0 : w_dst_rd;
    assign w_pl     = (LW'(r_j) < r_len) ? w_src_rd : '0;
    assign w_len_nx = r_len + LW'(TD);

    assign w_in_neg    = i_req.value[VALUE_BITS-1];
    assign w_in_mag    = w_in_neg ? (VALUE_BITS'(0) - i_req.value) : i_req.value;
    assign w_in_err    = (i_req.degree == '0) || (int'(i_req.degree) > MAX_DEGREE)
                       || (w_in_neg && !i_req.degree[0]);
    assign w_pass_root = ROOT_W'(w_in_mag) << FRAC_BITS;
    assign w_srch_root = r_neg ? (ROOT_W'(0) - ROOT_W'(r_root)) : ROOT_W'(r_root);

    nre_limb_mac u_mac (
        .i_a   (w_mac_a),
        .i_b   (w_dig),
        .i_acc (w_mac_acc),
        .i_cin (r_carry),
        .o_sum (w_mac_sum)
    );

    nre_tgt_limb #(
        .IDX_W (IW),
        .SH_W  (SHW)
    ) u_tgt (
        .i_mag   (r_mag),
        .i_shift (r_shift),
        .i_index (r_j),
        .o_limb  (w_tl)
    );

    always_comb begin
        n_state      = r_state;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_m          = r_m;
        n_shift      = r_shift;
        n_lt         = r_lt;
        n_root       = r_root;
        n_bit        = r_bit;
        n_len        = r_len;
        n_src        = r_src;
        n_one        = r_one;
        n_i          = r_i;
        n_kd         = r_kd;
        n_carry      = r_carry;
        n_cnt        = r_cnt;
        n_j          = r_j;
        n_srch       = r_srch;
        n_res_root   = r_res_root;
        n_res_status = r_res_status;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        w_we         = 1'b0;
        w_wd         = w_mac_sum[LIMB_W-1:0];

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mag   = w_in_mag;
                    n_neg   = w_in_neg;
                    n_m     = i_req.degree;
                    n_shift = SHW'(FRAC_BITS * int'(i_req.degree));
                    n_lt    = LW'((VALUE_BITS + FRAC_BITS * int'(i_req.degree) + LIMB_W - 1)
                                  / LIMB_W);
                    n_root  = '0;
                    n_bit   = BW'(ROOT_BITS - 1);
                    n_srch  = 1'b0;
                    if (w_in_err) begin
                        n_res_root   = '0;
                        n_res_status = ST_FAIL;
                        n_state      = S_DONE;
                    end else if (i_req.degree == DEGREE_BITS'(1)) begin
                        n_res_root   = w_in_neg ? (ROOT_W'(0) - w_pass_root) : w_pass_root;
                        n_res_status = ST_OK;
                        n_state      = S_DONE;
                    end else begin
                        n_res_status = ST_OK;
                        n_srch       = 1'b1;
                        n_state      = S_TRIAL;
                    end
                end
            end
            S_TRIAL: begin
                n_one   = 1'b1;
                n_len   = LW'(1);
                n_i     = '0;
                n_kd    = '0;
                n_carry = '0;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_we = 1'b1;
                if (LW'(r_i) < r_len) begin
                    w_wd    = w_mac_sum[LIMB_W-1:0];
                    n_carry = w_mac_sum[2*LIMB_W-1:LIMB_W];
                    n_i     = r_i + IW'(1);
                end else begin
                    w_wd    = r_carry;
                    n_carry = '0;
                    n_i     = '0;
                    if (r_kd == KW'(TD - 1)) begin
                        n_kd    = '0;
                        n_len   = w_len_nx;
                        n_src   = ~r_src;
                        n_one   = 1'b0;
                        n_cnt   = r_cnt + MW'(1);
                        n_j     = IW'(((w_len_nx > r_lt) ? w_len_nx : r_lt) - LW'(1));
                        n_state = S_CMP;
                    end else begin
                        n_kd = r_kd + KW'(1);
                    end
                end
            end
            S_CMP: begin
                if (w_pl > w_tl) begin
                    // power passed the target: trial bit stays clear
                    if (r_bit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_bit   = r_bit - BW'(1);
                        n_state = S_TRIAL;
                    end
                end else if (w_pl < w_tl || r_j == '0) begin
                    if (int'(r_cnt) == int'(r_m)) begin
                        n_root = w_t;
                        if (r_bit == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_bit   = r_bit - BW'(1);
                            n_state = S_TRIAL;
                        end
                    end else begin
                        n_len   = (r_len < r_lt) ? r_len : r_lt;
                        n_i     = '0;
                        n_kd    = '0;
                        n_carry = '0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_j = r_j - IW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out.root   = r_srch ? w_srch_root : r_res_root;
                    n_out.status = r_res_status;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_root      <= '0;
            r_bit       <= '0;
            r_cnt       <= '0;
            r_src       <= 1'b0;
            r_one       <= 1'b0;
            r_len       <= '0;
            r_i         <= '0;
            r_kd        <= '0;
            r_j         <= '0;
            r_srch      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_root      <= n_root;
            r_bit       <= n_bit;
            r_cnt       <= n_cnt;
            r_src       <= n_src;
            r_one       <= n_one;
            r_len       <= n_len;
            r_i         <= n_i;
            r_kd        <= n_kd;
            r_j         <= n_j;
            r_srch      <= n_srch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_m          <= n_m;
        r_shift      <= n_shift;
        r_lt         <= n_lt;
        r_carry      <= n_carry;
        r_res_root   <= n_res_root;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    // limb store: the destination is the buffer not selected as source
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            if (r_src) begin
                r_pw0[w_addr_d] <= w_wd;
            end else begin
                r_pw1[w_addr_d] <= w_wd;
            end
        end
    end

endmodule

`default_nettype wire
